@@ sv/sqrd_pkg.sv @@
// Shared types and codes for the sequence replay dedup cache.
// No dependencies; imported by the top level.
package sqrd_pkg;

  localparam int SeqW = 32;
  localparam int FpW  = 64;
  localparam int OcW  = 4;
  localparam int TagW = 32;

  localparam logic [1:0] VERDICT_FRESH    = 2'd0;
  localparam logic [1:0] VERDICT_REPLAY   = 2'd1;
  localparam logic [1:0] VERDICT_CONFLICT = 2'd2;
  localparam logic [1:0] VERDICT_NONMONO  = 2'd3;

  localparam logic [OcW-1:0] CONFLICT_CODE = 4'd15;

  localparam int EntryW = SeqW + FpW + OcW;

  typedef struct packed {
    logic [SeqW-1:0] seq_id;
    logic [FpW-1:0]  fingerprint;
    logic [OcW-1:0]  outcome;
  } entry_t;

  typedef struct packed {
    logic [SeqW-1:0] report_sequence;
    logic [OcW-1:0]  report_outcome;
    logic [1:0]      verdict;
  } result_t;

endpackage

@@ sv/sqrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the cache entries.
module sqrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sequence_replay_dedup_cache.sv @@
// Top level of the sequence replay dedup cache: sequencer, entry scan and state.
// Depends on sqrd_pkg and sqrd_ram.
//
// Usage:
//   Commands enter on the s_axis channel, one report per command leaves on
//   m_axis. A transfer happens when tvalid and tready are both high.
//   The command's kind (ordinary or hello) travels on s_axis_tuser.
//   Each command is worked on alone: s_axis_tready is high only while the
//   sequencer is idle. After a transfer the cache RAM is read one entry per
//   cycle and each entry is checked by a single sequence/fingerprint compare
//   unit as its data returns; the scan stops at the first valid match.
//   The time from input transfer to m_axis_tvalid is set by the scan over
//   the one RAM read port, so its worst case grows with CACHE_DEPTH; the
//   next transfer is taken once the report has gone into the output register.
//   The report sits in an output register, so the next command is taken
//   while it waits; if the receiver stalls, the following report is held
//   inside until the register frees.
//   Reset clears the valid bits, ring pointer, highest id and boot tag at
//   once; no clearing pass is needed. A hello with a new nonzero boot tag
//   clears the same state in the cycle of its transfer.
module sequence_replay_dedup_cache
  import sqrd_pkg::*;
#(
  parameter int CACHE_DEPTH = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: boot_tag[31:0], seq_id[63:32], fingerprint[127:64],
  //        outcome[131:128], zero pad[135:132]
  input  logic [135:0] s_axis_tdata,
  // tuser: command[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: verdict[1:0], report_outcome[5:2], report_sequence[37:6],
  //        zero pad[39:38]
  output logic [39:0]  m_axis_tdata
);

  localparam int IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [CACHE_DEPTH-1:0] valid_q;
  logic [IW-1:0]       ring_q;
  logic [SeqW-1:0]     highest_q;
  logic [TagW-1:0]     tag_q;

  logic [SeqW-1:0]     seq_q;
  logic [FpW-1:0]      fp_q;
  logic [OcW-1:0]      oc_q;

  logic [CW-1:0]       issue_q;
  logic                cmp_vld_q;
  logic [IW-1:0]       cmp_idx_q;
  logic                hit_q;
  logic                hit_fp_eq_q;
  logic [OcW-1:0]      hit_oc_q;
  result_t             res_q;
  logic                m_tvalid_q;
  logic [39:0]         m_tdata_q;

  logic                in_xfer;
  logic                in_cmd;
  logic [TagW-1:0]     in_tag;
  logic [SeqW-1:0]     in_seq;
  logic [FpW-1:0]      in_fp;
  logic [OcW-1:0]      in_oc;
  logic                new_epoch;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  entry_t              wr_entry;
  logic [EntryW-1:0]   rd_raw;
  entry_t              rd_entry;

  logic                seq_match;
  logic                scan_last;
  logic                nonmono;
  logic [IW-1:0]       ring_next;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_cmd  = s_axis_tuser;
  assign in_tag  = s_axis_tdata[31:0];
  assign in_seq  = s_axis_tdata[63:32];
  assign in_fp   = s_axis_tdata[127:64];
  assign in_oc   = s_axis_tdata[131:128];

  assign new_epoch = in_cmd && (in_tag != '0) && (in_tag != tag_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // Scan issue: one RAM read per cycle until all entries are requested or a hit
  assign rd_en   = (state_q == ST_SCAN) && (issue_q < CW'(CACHE_DEPTH));
  assign rd_addr = issue_q[IW-1:0];

  assign rd_entry  = entry_t'(rd_raw);
  assign seq_match = cmp_vld_q && valid_q[cmp_idx_q] && (rd_entry.seq_id == seq_q);
  assign scan_last = cmp_vld_q && (cmp_idx_q == IW'(CACHE_DEPTH - 1));

  assign nonmono   = (seq_q == '0) || ((highest_q != '0) && (seq_q <= highest_q));
  assign ring_next = (ring_q == IW'(CACHE_DEPTH - 1)) ? '0 : ring_q + 1'b1;

  assign wr_en                = (state_q == ST_DECIDE) && !hit_q;
  assign wr_entry.seq_id      = seq_q;
  assign wr_entry.fingerprint = fp_q;
  assign wr_entry.outcome     = nonmono ? CONFLICT_CODE : oc_q;

  sqrd_ram #(
    .WIDTH (EntryW),
    .DEPTH (CACHE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ring_q),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      ring_q      <= '0;
      highest_q   <= '0;
      tag_q       <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      m_tvalid_q  <= 1'b0;
    end else begin
      // Drop the report once taken, unless a new one is loaded this cycle
      if (m_axis_tready && (state_q != ST_OUT)) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            seq_q     <= in_seq;
            fp_q      <= in_fp;
            oc_q      <= in_oc;
            issue_q   <= '0;
            cmp_vld_q <= 1'b0;
            hit_q     <= 1'b0;
            if (new_epoch) begin
              valid_q   <= '0;
              ring_q    <= '0;
              highest_q <= '0;
              tag_q     <= in_tag;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_q <= issue_q + 1'b1;
          end
          cmp_vld_q <= rd_en;
          cmp_idx_q <= rd_addr;
          // Stop at the first valid match; lower entries are checked first
          if (seq_match) begin
            hit_q       <= 1'b1;
            hit_fp_eq_q <= (rd_entry.fingerprint == fp_q);
            hit_oc_q    <= rd_entry.outcome;
            state_q     <= ST_DECIDE;
          end else if (scan_last) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_q.report_sequence <= seq_q;
          if (hit_q) begin
            res_q.verdict        <= hit_fp_eq_q ? VERDICT_REPLAY : VERDICT_CONFLICT;
            res_q.report_outcome <= hit_fp_eq_q ? hit_oc_q : CONFLICT_CODE;
          end else begin
            valid_q[ring_q] <= 1'b1;
            ring_q          <= ring_next;
            if (nonmono) begin
              res_q.verdict        <= VERDICT_NONMONO;
              res_q.report_outcome <= CONFLICT_CODE;
            end else begin
              res_q.verdict        <= VERDICT_FRESH;
              res_q.report_outcome <= oc_q;
              highest_q            <= seq_q;
            end
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold the report until the output register is free
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {2'b00, res_q.report_sequence, res_q.report_outcome, res_q.verdict};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
